// ----- rtl/assert_macros.svh -----
// assertion macros used by life_generation_step
// expects signals named clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lgs check failed");

// next-cycle implication, checked out of reset
`define LGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lgs check failed");

`endif

// ----- rtl/lgs_pkg.sv -----
// lgs_pkg: shared types and constants of the life generation step block
// no dependencies
package lgs_pkg;

  localparam int ROW_IDX_W = 5;   // width of a row index field
  localparam int CELL_W    = 32;  // width of a row of cells on the ports
  localparam int CFG_W     = 6;   // width of a configuration register
  localparam int CFG_IDX_W = 1;   // width of the register index

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT  = 4'd3;
  localparam logic [3:0] SURVIVE_LOW  = 4'd2;
  localparam logic [3:0] SURVIVE_HIGH = 4'd3;
  localparam int         NEIGHBOURS   = 8;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // control to one row cell of the chain
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- rtl/life_generation_step.sv -----
// life_generation_step: top level of the b3/s23 life generation block
// depends on lgs_pkg, lgs_row_cell, lgs_rule and assert_macros.svh
//
// The grid lives in a chain of GRID_ROWS row cells, cell k holding row k while the
// block is idle. A load beat writes one row straight into its cell, masked to the
// active columns; rows at or above rows_in_use are dropped. An advance beat holds
// the input side stalled while the block runs one step per row, also while the
// result side stalls with a row waiting in the output register: the chain shifts
// one row per cycle toward cell 0 unless the result side stalls, a single rule unit
// computes the new row from the row leaving cell 0, the row held from the step
// before and the row in cell 1, and the new row enters at the far end, so after
// GRID_ROWS shifts every cell holds its row again. Each active new row goes out as
// one beat in row order via the output register once the run state is entered, the
// last one flagged by out_last_row; inactive rows come back cleared and emit nothing.
// The input side stalls for the whole advance; a finished result may still wait in
// the output register while the next input beat is taken. Configuration writes are
// taken at any time but are meant to happen only while idle.
`include "assert_macros.svh"

module life_generation_step #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]         cfg_wdata,
  // input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [lgs_pkg::ROW_IDX_W-1:0]     in_row_index,
  input  logic [lgs_pkg::CELL_W-1:0]        in_row_cells,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lgs_pkg::ROW_IDX_W-1:0]     out_row_index,
  output logic [lgs_pkg::CELL_W-1:0]        out_row_cells,
  output logic                              out_last_row
);

  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;  // row position
  localparam int CW = $clog2(GRID_ROWS + 1);                     // active row count
  localparam int KW = $clog2(GRID_COLS + 1);                     // active col count
  localparam logic [RW-1:0] LAST_STEP = RW'(GRID_ROWS - 1);

  // configuration registers
  logic [lgs_pkg::CFG_W-1:0] rows_r, rows_nxt;
  logic [lgs_pkg::CFG_W-1:0] cols_r, cols_nxt;

  // sequencer
  lgs_pkg::state_t state_r, state_nxt;
  logic [RW-1:0]   step_r, step_nxt;
  logic            step_go;
  logic            in_accept;
  logic            load_go;
  logic            adv_go;

  // row chain
  logic [GRID_COLS-1:0]     cell_q   [GRID_ROWS];
  lgs_pkg::cell_ctrl_t      cell_ctrl[GRID_ROWS];
  logic [GRID_COLS-1:0]     load_row;
  logic [GRID_COLS-1:0]     col_mask;
  logic [GRID_COLS-1:0]     prev_r, prev_nxt;
  logic [GRID_COLS-1:0]     cur_row;
  logic [GRID_COLS-1:0]     below_row;
  logic [GRID_COLS-1:0]     rule_row;
  logic [GRID_COLS-1:0]     new_row;
  logic [CW-1:0]            act_rows;
  logic [KW-1:0]            act_cols;
  logic                     row_active;
  logic                     below_active;
  logic                     row_last;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [lgs_pkg::ROW_IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [lgs_pkg::CELL_W-1:0]       out_cells_r, out_cells_nxt;
  logic                             out_last_r, out_last_nxt;
  logic [lgs_pkg::CELL_W-1:0]       new_port;

  // ---------------------------------------------------------------- config
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      case (cfg_index)
        lgs_pkg::CFG_ROWS_IN_USE: rows_nxt = cfg_wdata;
        lgs_pkg::CFG_COLS_IN_USE: cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // register values above the grid saturate to the grid size
  assign act_rows = (int'(rows_r) > GRID_ROWS) ? CW'(GRID_ROWS) : CW'(rows_r);
  assign act_cols = (int'(cols_r) > GRID_COLS) ? KW'(GRID_COLS) : KW'(cols_r);

  for (genvar j = 0; j < GRID_COLS; j++) begin : g_mask
    assign col_mask[j] = (int'(act_cols) > j);
    // port bits beyond the grid width are dropped, missing ones read dead
    if (j < lgs_pkg::CELL_W) begin : g_in
      assign load_row[j] = in_row_cells[j] & col_mask[j];
    end else begin : g_zero
      assign load_row[j] = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign in_accept = in_valid && !in_stall;
  assign load_go   = in_accept && (in_mode == lgs_pkg::MODE_LOAD)
                     && (int'(in_row_index) < int'(act_rows));
  assign adv_go    = in_accept && (in_mode == lgs_pkg::MODE_ADVANCE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lgs_pkg::ST_IDLE: begin
        if (adv_go) begin
          state_nxt = lgs_pkg::ST_RUN;
        end
      end
      lgs_pkg::ST_RUN: begin
        if (step_go && step_r == LAST_STEP) begin
          state_nxt = lgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lgs_pkg::ST_IDLE;
    endcase
  end

  // a step needs room in the output register for its row
  always_comb begin
    in_stall = 1'b0;
    step_go  = 1'b0;
    case (state_r)
      lgs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        step_go  = 1'b0;
      end
      lgs_pkg::ST_RUN: begin
        in_stall = 1'b1;
        step_go  = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
        step_go  = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (step_go) begin
      step_nxt = (step_r == LAST_STEP) ? '0 : step_r + RW'(1);
    end
  end

  // ---------------------------------------------------------------- row chain
  // everything outside the active area reads as dead
  assign row_active   = int'(step_r) < int'(act_rows);
  assign below_active = (int'(step_r) + 1) < int'(act_rows);
  assign row_last     = (int'(step_r) + 1) == int'(act_rows);

  assign cur_row   = cell_q[0] & col_mask;
  assign below_row = below_active ? (cell_q[1] & col_mask) : '0;

  lgs_rule #(
    .GRID_COLS (GRID_COLS)
  ) u_rule (
    .row_above (prev_r),
    .row_cur   (cur_row),
    .row_below (below_row),
    .row_new   (rule_row)
  );

  // inactive rows come back cleared
  assign new_row = row_active ? (rule_row & col_mask) : '0;

  // row above the next one is the row leaving cell 0 now; zero above row 0
  always_comb begin
    prev_nxt = prev_r;
    if (adv_go) begin
      prev_nxt = '0;
    end else if (step_go) begin
      prev_nxt = cur_row;
    end
  end

  for (genvar k = 0; k < GRID_ROWS; k++) begin : g_cell
    logic [GRID_COLS-1:0] from_next;

    if (k == GRID_ROWS - 1) begin : g_tail
      assign from_next = new_row;
    end else begin : g_link
      assign from_next = cell_q[k+1];
    end

    assign cell_ctrl[k].shift = step_go;
    assign cell_ctrl[k].load  = load_go && (int'(in_row_index) == k);

    lgs_row_cell #(
      .GRID_COLS (GRID_COLS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl[k]),
      .shift_in  (from_next),
      .load_data (load_row),
      .row_q     (cell_q[k])
    );
  end

  // ---------------------------------------------------------------- output
  for (genvar j = 0; j < lgs_pkg::CELL_W; j++) begin : g_out
    if (j < GRID_COLS) begin : g_bit
      assign new_port[j] = new_row[j];
    end else begin : g_zero
      assign new_port[j] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_cells_nxt = out_cells_r;
    out_last_nxt  = out_last_r;
    if (step_go) begin
      out_valid_nxt = row_active;
      out_idx_nxt   = lgs_pkg::ROW_IDX_W'(step_r);
      out_cells_nxt = new_port;
      out_last_nxt  = row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_idx_r;
  assign out_row_cells = out_cells_r;
  assign out_last_row  = out_last_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= lgs_pkg::CFG_W'(32);
      cols_r      <= lgs_pkg::CFG_W'(32);
      state_r     <= lgs_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r      <= prev_nxt;
    out_idx_r   <= out_idx_nxt;
    out_cells_r <= out_cells_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ---------------------------------------------------------------- checks
  // step counter rests at zero between advances
  `LGS_ASSERT_NOW(a_idle_step_zero, state_r == lgs_pkg::ST_IDLE, step_r == '0)
  // the chain moves one row per granted step
  `LGS_ASSERT_NEXT(a_step_inc, step_go && step_r != LAST_STEP, step_r == $past(step_r) + RW'(1))
  // no new result beat appears outside an advance
  `LGS_ASSERT_NEXT(a_no_spurious_beat, !out_valid_r && state_r == lgs_pkg::ST_IDLE, !out_valid_r)

endmodule

// ----- rtl/lgs_row_cell.sv -----
// lgs_row_cell: one row of the grid, loaded directly or shifted from its neighbor
// depends on lgs_pkg
module lgs_row_cell #(
  parameter int GRID_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lgs_pkg::cell_ctrl_t   ctrl,
  input  logic [GRID_COLS-1:0]  shift_in,
  input  logic [GRID_COLS-1:0]  load_data,
  output logic [GRID_COLS-1:0]  row_q
);

  logic [GRID_COLS-1:0] row_r;
  logic [GRID_COLS-1:0] row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (ctrl.load) begin
      row_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

// ----- rtl/lgs_rule.sv -----
// lgs_rule: next state of one row from the rows above, at and below it
// depends on lgs_pkg; inputs must already be masked to the active columns
module lgs_rule #(
  parameter int GRID_COLS = 32
) (
  input  logic [GRID_COLS-1:0] row_above,
  input  logic [GRID_COLS-1:0] row_cur,
  input  logic [GRID_COLS-1:0] row_below,
  output logic [GRID_COLS-1:0] row_new
);

  // one dead column padded on each side, no wrap
  logic [GRID_COLS+1:0] pad_a;
  logic [GRID_COLS+1:0] pad_c;
  logic [GRID_COLS+1:0] pad_b;

  assign pad_a = {1'b0, row_above, 1'b0};
  assign pad_c = {1'b0, row_cur,   1'b0};
  assign pad_b = {1'b0, row_below, 1'b0};

  for (genvar j = 0; j < GRID_COLS; j++) begin : g_col
    logic [lgs_pkg::NEIGHBOURS-1:0] nb;
    logic [3:0]                     cnt;

    assign nb = {pad_a[j], pad_a[j+1], pad_a[j+2],
                 pad_c[j],             pad_c[j+2],
                 pad_b[j], pad_b[j+1], pad_b[j+2]};

    always_comb begin
      cnt = '0;
      for (int k = 0; k < lgs_pkg::NEIGHBOURS; k++) begin
        cnt = cnt + 4'(nb[k]);
      end
    end

    assign row_new[j] = row_cur[j] ? (cnt == lgs_pkg::SURVIVE_LOW || cnt == lgs_pkg::SURVIVE_HIGH)
                                   : (cnt == lgs_pkg::BIRTH_COUNT);
  end

endmodule

// ----- tb/tb_life_generation_step.sv -----
`timescale 1ns / 100ps
// tb_life_generation_step: self-checking testbench of the b3/s23 life generation block
// holds a shadow grid that predicts every emitted row; needs lgs_pkg and life_generation_step

module tb_life_generation_step;

  localparam int GRID_ROWS   = 32;
  localparam int GRID_COLS   = 32;
  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 5;
  localparam int SETTLE_LEN  = GRID_ROWS + 8;   // an advance keeps shifting after its last beat
  localparam int HOLD_CYCLES = 150;             // long receiver hold-off
  localparam int RANDOM_BEATS = 105;
  localparam int TIMEOUT_NS  = 2_000_000;

  // b3/s23 rule
  localparam int RULE_BORN     = 3;
  localparam int RULE_KEEP_MIN = 2;
  localparam int RULE_KEEP_MAX = 3;

  typedef struct {
    logic [lgs_pkg::ROW_IDX_W-1:0] idx;
    logic [lgs_pkg::CELL_W-1:0]    cells;
    logic                          last;
  } gen_row_t;

  typedef enum logic {
    STEP_BEAT,
    STEP_REG
  } step_kind_t;

  // one line of the directed table; dead_rows >= 0 types the result in as
  // that many dead rows, -1 leaves it to the shadow grid
  typedef struct {
    step_kind_t                    kind;
    logic                          mode;
    logic [lgs_pkg::ROW_IDX_W-1:0] idx;
    logic [lgs_pkg::CELL_W-1:0]    cells;
    logic [lgs_pkg::CFG_IDX_W-1:0] sel;
    logic [lgs_pkg::CFG_W-1:0]     val;
    int                            dead_rows;
  } dir_step_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_mode;
  logic [lgs_pkg::ROW_IDX_W-1:0] in_row_index;
  logic [lgs_pkg::CELL_W-1:0]    in_row_cells;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [lgs_pkg::ROW_IDX_W-1:0] out_row_index;
  logic [lgs_pkg::CELL_W-1:0]    out_row_cells;
  logic                          out_last_row;

  // shadow of the block: grid and both size registers
  logic [GRID_COLS-1:0]      shadow_grid [GRID_ROWS];
  logic [lgs_pkg::CFG_W-1:0] shadow_rows;
  logic [lgs_pkg::CFG_W-1:0] shadow_cols;

  gen_row_t  next_gen_rows [$];   // rows still owed by the block, oldest first
  dir_step_t directed_steps [$];
  int        mismatches = 0;

  // sender and receiver pacing
  bit valid_up  = 1'b0;
  int burst_left = 0;
  bit hold_req  = 1'b0;
  int hold_cnt  = 0;
  int seg_left  = 0;
  int stall_pct = 0;

  life_generation_step #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_row_index (in_row_index),
    .in_row_cells (in_row_cells),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_index(out_row_index),
    .out_row_cells(out_row_cells),
    .out_last_row (out_last_row)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow grid
  // ---------------------------------------------------------------------------

  // register values above the grid size saturate
  function automatic int active_rows();
    return (shadow_rows > GRID_ROWS) ? GRID_ROWS : int'(shadow_rows);
  endfunction

  function automatic int active_cols();
    return (shadow_cols > GRID_COLS) ? GRID_COLS : int'(shadow_cols);
  endfunction

  function automatic logic [lgs_pkg::CELL_W-1:0] col_mask(int nc);
    logic [lgs_pkg::CELL_W:0] m;
    m = ({{lgs_pkg::CELL_W{1'b0}}, 1'b1} << nc) - 1'b1;
    return m[lgs_pkg::CELL_W-1:0];
  endfunction

  // anything outside the active area is dead, no wrap-around
  function automatic int live_at(int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 0;
    return int'(shadow_grid[r][c]);
  endfunction

  function automatic void advance_shadow_grid();
    logic [GRID_COLS-1:0] nxt [GRID_ROWS];
    int nr;
    int nc;
    int n;
    nr = active_rows();
    nc = active_cols();
    for (int r = 0; r < GRID_ROWS; r++) nxt[r] = '0;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) n += live_at(i + dr, j + dc, nr, nc);
        if (live_at(i, j, nr, nc) != 0)
          nxt[i][j] = (n == RULE_KEEP_MIN || n == RULE_KEEP_MAX);
        else
          nxt[i][j] = (n == RULE_BORN);
      end
    end
    // stale cells outside the active area are cleared here too
    shadow_grid = nxt;
  endfunction

  // apply one accepted beat and queue the rows it owes
  function automatic void track_beat(logic mode, logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                                     logic [lgs_pkg::CELL_W-1:0] cells, int dead_rows);
    gen_row_t row;
    int       owed;
    if (mode == lgs_pkg::MODE_LOAD) begin
      // loads outside the active rows are dropped, extra columns masked
      if (idx < active_rows()) shadow_grid[idx] = cells & col_mask(active_cols());
    end else begin
      advance_shadow_grid();
      owed = (dead_rows >= 0) ? dead_rows : active_rows();
      for (int i = 0; i < owed; i++) begin
        row.idx   = lgs_pkg::ROW_IDX_W'(i);
        row.cells = (dead_rows >= 0) ? '0 : shadow_grid[i];
        row.last  = (i == owed - 1);
        next_gen_rows.push_back(row);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------

  function automatic dir_step_t load_step(logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                                          logic [lgs_pkg::CELL_W-1:0] cells);
    dir_step_t s;
    s = '{STEP_BEAT, lgs_pkg::MODE_LOAD, idx, cells, lgs_pkg::CFG_ROWS_IN_USE, '0, -1};
    return s;
  endfunction

  function automatic dir_step_t advance_step(int dead_rows);
    dir_step_t s;
    s = '{STEP_BEAT, lgs_pkg::MODE_ADVANCE, '0, '0, lgs_pkg::CFG_ROWS_IN_USE, '0, dead_rows};
    return s;
  endfunction

  function automatic dir_step_t reg_step(logic [lgs_pkg::CFG_IDX_W-1:0] sel,
                                         logic [lgs_pkg::CFG_W-1:0] val);
    dir_step_t s;
    s = '{STEP_REG, lgs_pkg::MODE_LOAD, '0, '0, sel, val, -1};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // random picks
  // ---------------------------------------------------------------------------

  // grid size: mostly in range, with zero, one, full size and above-size values
  function automatic logic [lgs_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return lgs_pkg::CFG_W'(1);
      2:       return lgs_pkg::CFG_W'(GRID_ROWS);
      3:       return '1;
      4, 5:    return lgs_pkg::CFG_W'($urandom_range(33, 63));
      default: return lgs_pkg::CFG_W'($urandom_range(2, 32));
    endcase
  endfunction

  // row contents of varied density
  function automatic logic [lgs_pkg::CELL_W-1:0] pick_cells();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom() & $urandom();
      4:       return $urandom() | $urandom();
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // offer one beat, hold it until taken, then maybe open a gap
  task automatic send_beat(logic mode, logic [lgs_pkg::ROW_IDX_W-1:0] idx,
                           logic [lgs_pkg::CELL_W-1:0] cells, int dead_rows);
    int gap;
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_row_index <= idx;
    in_row_cells <= cells;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_beat(mode, idx, cells, dead_rows);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // long bursts now and then give stretches without idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = $urandom_range(1, 10);
      drop_valid();
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(logic [lgs_pkg::CFG_IDX_W-1:0] sel, logic [lgs_pkg::CFG_W-1:0] val);
    drop_valid();
    while (next_gen_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == lgs_pkg::CFG_ROWS_IN_USE) shadow_rows = val;
    else shadow_cols = val;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern in segments, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      // block fills up and must stall its input meanwhile
      out_stall <= 1'b1;
      hold_cnt++;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 50);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every taken beat against the oldest owed row
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gen_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (next_gen_rows.size() == 0) begin
        $display("%0t: unexpected result beat row %0d cells %h last %b",
                 $time, out_row_index, out_row_cells, out_last_row);
        mismatches++;
      end else begin
        want = next_gen_rows.pop_front();
        if (out_row_index !== want.idx) begin
          $display("%0t: out_row_index expected %0d actual %0d", $time, want.idx, out_row_index);
          mismatches++;
        end
        if (out_row_cells !== want.cells) begin
          $display("%0t: out_row_cells of row %0d expected %h actual %h",
                   $time, want.idx, want.cells, out_row_cells);
          mismatches++;
        end
        if (out_last_row !== want.last) begin
          $display("%0t: out_last_row of row %0d expected %b actual %b",
                   $time, want.idx, want.last, out_last_row);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                            nr;
    int                            taken;
    int                            n_items;
    int                            phase;
    logic                          mode;
    logic [lgs_pkg::ROW_IDX_W-1:0] idx;
    logic [lgs_pkg::CELL_W-1:0]    cells;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = lgs_pkg::CFG_ROWS_IN_USE;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_mode      = lgs_pkg::MODE_LOAD;
    in_row_index = '0;
    in_row_cells = '0;
    for (int r = 0; r < GRID_ROWS; r++) shadow_grid[r] = '0;
    shadow_rows = lgs_pkg::CFG_W'(GRID_ROWS);
    shadow_cols = lgs_pkg::CFG_W'(GRID_COLS);

    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_steps = '{
      advance_step(GRID_ROWS),                          // grid is all dead after reset
      load_step(5'd0,  32'hFFFF_FFFF),                  // full rows on both edges
      load_step(5'd31, 32'hFFFF_FFFF),
      load_step(5'd10, 32'h0000_000E),                  // blinker
      load_step(5'd20, 32'h0000_0006),                  // block, stays put
      load_step(5'd21, 32'h0000_0006),
      load_step(5'd15, 32'h8000_0001),                  // lone cells on both column edges
      advance_step(-1),
      advance_step(-1),
      reg_step(lgs_pkg::CFG_ROWS_IN_USE, 6'd0),         // no active row: nothing comes out
      advance_step(0),
      reg_step(lgs_pkg::CFG_ROWS_IN_USE, 6'd5),
      reg_step(lgs_pkg::CFG_COLS_IN_USE, 6'd0),         // no active column: dead rows only
      advance_step(5),
      reg_step(lgs_pkg::CFG_ROWS_IN_USE, 6'd63),        // above grid size, saturates
      reg_step(lgs_pkg::CFG_COLS_IN_USE, 6'd63),
      load_step(5'd31, 32'hE000_0007),
      load_step(5'd30, 32'h8000_0001),
      load_step(5'd0,  32'h5555_AAAA),
      advance_step(-1),
      reg_step(lgs_pkg::CFG_ROWS_IN_USE, 6'd4),         // rows above 3 now stale
      reg_step(lgs_pkg::CFG_COLS_IN_USE, 6'd5),
      load_step(5'd4,  32'hFFFF_FFFF),                  // outside active rows, dropped
      load_step(5'd1,  32'hFFFF_FFFF),                  // masked to five columns
      load_step(5'd2,  32'h0000_001F),
      advance_step(-1),
      reg_step(lgs_pkg::CFG_ROWS_IN_USE, 6'd1),
      reg_step(lgs_pkg::CFG_COLS_IN_USE, 6'd1),
      load_step(5'd0,  32'h0000_0001),
      advance_step(1)                                   // lone cell dies
    };

    foreach (directed_steps[k]) begin
      if (directed_steps[k].kind == STEP_REG)
        write_reg(directed_steps[k].sel, directed_steps[k].val);
      else
        send_beat(directed_steps[k].mode, directed_steps[k].idx,
                  directed_steps[k].cells, directed_steps[k].dead_rows);
    end

    // random phases: a size setting, then loads into the active rows mixed
    // with advances, and a little noise aimed at any row
    taken = 0;
    phase = 0;
    while (taken < RANDOM_BEATS) begin
      if (phase == 1) begin
        // full grid and an advance first, so the hold-off backs up the block
        write_reg(lgs_pkg::CFG_ROWS_IN_USE, lgs_pkg::CFG_W'(GRID_ROWS));
        write_reg(lgs_pkg::CFG_COLS_IN_USE, lgs_pkg::CFG_W'(GRID_COLS));
        hold_req = 1'b1;
      end else begin
        write_reg(lgs_pkg::CFG_ROWS_IN_USE, pick_size());
        write_reg(lgs_pkg::CFG_COLS_IN_USE, pick_size());
      end
      nr = active_rows();
      n_items = $urandom_range(4, 16);
      for (int k = 0; k < n_items; k++) begin
        cells = pick_cells();
        if ((phase == 1 && k == 0) || $urandom_range(0, 3) == 0) begin
          mode = lgs_pkg::MODE_ADVANCE;
          idx  = lgs_pkg::ROW_IDX_W'($urandom_range(0, 31));
        end else begin
          mode = lgs_pkg::MODE_LOAD;
          if (nr > 0 && $urandom_range(0, 7) != 0)
            idx = lgs_pkg::ROW_IDX_W'($urandom_range(0, nr - 1));
          else
            idx = lgs_pkg::ROW_IDX_W'($urandom_range(0, 31));
        end
        // every sent beat counts toward the run length
        taken++;
        send_beat(mode, idx, cells, -1);
      end
      phase++;
    end

    // drain, then let the last advance finish its shifting
    drop_valid();
    while (next_gen_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatches == 0 && next_gen_rows.size() == 0) begin
      $display("life_generation_step test passed");
    end else begin
      $display("life_generation_step test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("life_generation_step test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lgs_pkg.sv
rtl/lgs_row_cell.sv
rtl/lgs_rule.sv
rtl/life_generation_step.sv
tb/tb_life_generation_step.sv
